[rtl/core/epdt_pkg.sv]
// ---------------------------------------------------------------------------
// epdt_pkg: shared types and constants for the epoch to date converter
// Holds the shared subtractor bundles, calendar tables and register indexes.
// ---------------------------------------------------------------------------
package epdt_pkg;

  localparam int unsigned SUB_W = 17;

  // 86400 = 675 << 7, so the seconds are shifted down by 7 before dividing
  localparam int unsigned DAY_SHIFT = 7;
  // ceil(2^35 / 675): exact quotient for any 25-bit dividend
  localparam logic [25:0] DAY_RECIP       = 26'd50903317;
  localparam int unsigned DAY_RECIP_SHIFT = 35;
  localparam logic [SUB_W-1:0] YEAR_LEN      = SUB_W'(365);
  localparam logic [SUB_W-1:0] LEAP_YEAR_LEN = SUB_W'(366);
  localparam logic signed [17:0] SECS_PER_HOUR = 18'sd3600;

  localparam logic [1:0] YEAR_MOD4_BASE   = 2'd2;    // 1970 mod 4
  localparam logic [6:0] YEAR_MOD100_BASE = 7'd70;
  localparam logic [8:0] YEAR_MOD400_BASE = 9'd370;
  localparam logic [3:0] LAST_MONTH_IDX   = 4'd11;

  // Configuration register indexes
  localparam logic CFG_DST_REGION = 1'b0;
  localparam logic CFG_TZ_OFFSET  = 1'b1;
  localparam logic [4:0] TZ_RESET = 5'd2;

  typedef enum logic [1:0] {
    REGION_EU = 2'd0,
    REGION_NA = 2'd1,
    REGION_AU = 2'd2,
    REGION_SA = 2'd3
  } dst_region_t;

  typedef struct packed {
    logic [SUB_W-1:0] a;
    logic [SUB_W-1:0] b;
  } sub_req_t;

  typedef struct packed {
    logic [SUB_W-1:0] diff;
    logic             ge;
  } sub_rsp_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
      4'd1:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one conditional subtract
  function automatic logic [2:0] mod7(input logic [16:0] x);
    logic [5:0] s;
    logic [3:0] s2;
    s  = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
       + 6'(x[16:15]);
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

[rtl/core/epdt_subu.sv]
// ---------------------------------------------------------------------------
// epdt_subu: shared compare and subtract unit
// One subtractor used by the year walk and the month walk.
// ---------------------------------------------------------------------------
module epdt_subu (
  input  epdt_pkg::sub_req_t req,
  output epdt_pkg::sub_rsp_t rsp
);

  logic [epdt_pkg::SUB_W:0] full;

  assign full     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = full[epdt_pkg::SUB_W-1:0];
  assign rsp.ge   = ~full[epdt_pkg::SUB_W];

endmodule

[rtl/core/epdt_dst.sv]
// ---------------------------------------------------------------------------
// epdt_dst: daylight-saving rule decode
// Applies the selected region rule to month, day of month and weekday.
// ---------------------------------------------------------------------------
module epdt_dst (
  input  epdt_pkg::dst_region_t region,
  input  logic [3:0]            month_num,
  input  logic [4:0]            day_of_month,
  input  logic [2:0]            weekday,
  output logic                  dst_active
);

  logic signed [6:0] d;

  assign d = $signed({2'b00, day_of_month}) - $signed({4'b0000, weekday});

  always_comb begin
    case (region)
      epdt_pkg::REGION_EU: begin
        dst_active = (month_num > 4'd3 && month_num < 4'd10)
                   || (month_num == 4'd3 && d >= 7'sd25)
                   || (month_num == 4'd10 && d <= 7'sd24);
      end
      epdt_pkg::REGION_NA: begin
        dst_active = (month_num > 4'd3 && month_num < 4'd11)
                   || (month_num == 4'd3 && d >= 7'sd8)
                   || (month_num == 4'd11 && d <= 7'sd0);
      end
      epdt_pkg::REGION_AU: begin
        dst_active = (month_num > 4'd10 || month_num < 4'd4)
                   || (month_num == 4'd10 && d >= 7'sd1)
                   || (month_num == 4'd4 && d <= 7'sd0);
      end
      default: begin
        dst_active = (month_num > 4'd9 || month_num < 4'd4)
                   || (month_num == 4'd9 && d >= 7'sd1)
                   || (month_num == 4'd4 && d <= 7'sd0);
      end
    endcase
  end

endmodule

[rtl/core/epoch_to_date_dst_check.sv]
// ---------------------------------------------------------------------------
// epoch_to_date_dst_check: Unix epoch to local date with daylight-saving flag
// Sequencer around one shared subtractor: day count, year walk, month walk.
// ---------------------------------------------------------------------------
// One item at a time. After acceptance an item passes through these steps
// until its result is offered: reciprocal multiplication for the division by
// 86400, the weekday step, one year step for each whole year walked from 1970
// (0 to 136) plus a final one, one month step for each whole month walked (0
// to 11) plus a final one, and the load of the output register. The year walk
// on the shared subtractor takes the most steps. in_ready is high only when
// the sequencer is idle; a finished result waits in the output register while
// the next item is taken. Write configuration through cfg_wr_en only while no
// item is in flight; index 0 selects the region rule, index 1 the signed hour
// offset.
module epoch_to_date_dst_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_month_num,
  output logic [4:0]  out_day_of_month,
  output logic [2:0]  out_weekday,
  output logic        out_dst_active
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  epdt_pkg::dst_region_t region_r;
  logic [4:0]            tz_r;
  logic [24:0]           sec_hi_r, sec_hi_nxt;
  logic [15:0]           num_r, num_nxt;
  logic [1:0]            m4_r, m4_nxt;
  logic [6:0]            m100_r, m100_nxt;
  logic [8:0]            m400_r, m400_nxt;
  logic [3:0]            mon_r, mon_nxt;
  logic [2:0]            wd_r, wd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [3:0]            out_month_r, out_month_nxt;
  logic [4:0]            out_day_r, out_day_nxt;
  logic [2:0]            out_wd_r, out_wd_nxt;
  logic                  out_dst_r, out_dst_nxt;

  epdt_pkg::sub_req_t    sub_req;
  epdt_pkg::sub_rsp_t    sub_rsp;

  logic signed [17:0]    tz_secs;
  logic [31:0]           local_secs;
  logic [50:0]           day_prod;
  logic                  leap;
  logic [3:0]            res_month;
  logic [4:0]            res_day;
  logic                  res_dst;
  logic                  in_acc;
  logic                  load_out;

  epdt_subu u_subu (
    .req (sub_req),
    .rsp (sub_rsp)
  );

  epdt_dst u_dst (
    .region       (region_r),
    .month_num    (res_month),
    .day_of_month (res_day),
    .weekday      (wd_r),
    .dst_active   (res_dst)
  );

  assign tz_secs    = 18'($signed(tz_r)) * epdt_pkg::SECS_PER_HOUR;
  assign local_secs = in_epoch_seconds + 32'(tz_secs);
  assign day_prod   = 51'(sec_hi_r) * 51'(epdt_pkg::DAY_RECIP);
  assign leap       = (m4_r == 2'd0) && ((m100_r != 7'd0) || (m400_r == 9'd0));
  assign res_month  = mon_r + 4'd1;
  assign res_day    = num_r[4:0] + 5'd1;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    sub_req.a = {1'b0, num_r};
    sub_req.b = epdt_pkg::YEAR_LEN;
    case (state_r)
      ST_YEAR: begin
        sub_req.b = leap ? epdt_pkg::LEAP_YEAR_LEN : epdt_pkg::YEAR_LEN;
      end
      ST_MONTH: begin
        sub_req.b = epdt_pkg::SUB_W'(epdt_pkg::month_len(mon_r, leap));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sec_hi_nxt    = sec_hi_r;
    num_nxt       = num_r;
    m4_nxt        = m4_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    mon_nxt       = mon_r;
    wd_nxt        = wd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_wd_nxt    = out_wd_r;
    out_dst_nxt   = out_dst_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sec_hi_nxt = local_secs[31:epdt_pkg::DAY_SHIFT];
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        // day count = (seconds >> 7) / 675 by reciprocal multiplication
        num_nxt   = day_prod[epdt_pkg::DAY_RECIP_SHIFT+15:epdt_pkg::DAY_RECIP_SHIFT];
        state_nxt = ST_WDAY;
      end
      ST_WDAY: begin
        // 1970-01-01 was a Thursday
        wd_nxt    = epdt_pkg::mod7({1'b0, num_r} + 17'd4);
        m4_nxt    = epdt_pkg::YEAR_MOD4_BASE;
        m100_nxt  = epdt_pkg::YEAR_MOD100_BASE;
        m400_nxt  = epdt_pkg::YEAR_MOD400_BASE;
        state_nxt = ST_YEAR;
      end
      ST_YEAR: begin
        if (sub_rsp.ge) begin
          num_nxt  = sub_rsp.diff[15:0];
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
        end else begin
          mon_nxt   = 4'd0;
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (sub_rsp.ge && mon_r != epdt_pkg::LAST_MONTH_IDX) begin
          num_nxt = sub_rsp.diff[15:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_month_nxt = res_month;
          out_day_nxt   = res_day;
          out_wd_nxt    = wd_r;
          out_dst_nxt   = res_dst;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      region_r    <= epdt_pkg::REGION_EU;
      tz_r        <= epdt_pkg::TZ_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        if (cfg_index == epdt_pkg::CFG_DST_REGION) begin
          region_r <= epdt_pkg::dst_region_t'(cfg_wdata[1:0]);
        end else begin
          tz_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sec_hi_r    <= sec_hi_nxt;
    num_r       <= num_nxt;
    m4_r        <= m4_nxt;
    m100_r      <= m100_nxt;
    m400_r      <= m400_nxt;
    mon_r       <= mon_nxt;
    wd_r        <= wd_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_wd_r    <= out_wd_nxt;
    out_dst_r   <= out_dst_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_month_num    = out_month_r;
  assign out_day_of_month = out_day_r;
  assign out_weekday      = out_wd_r;
  assign out_dst_active   = out_dst_r;

endmodule
